// ===== hdl/kss_pkg.sv =====
`default_nettype none
package kss_pkg;

    localparam int DEPTH      = 1024;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int K_W        = 11;
    localparam int OP_W       = 2;
    localparam int DP_W       = 4;

    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_SELECT = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [DATA_WIDTH-1:0] INT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    localparam logic [DP_W-1:0] DP_NOP    = 4'd0;
    localparam logic [DP_W-1:0] DP_LOAD   = 4'd1;
    localparam logic [DP_W-1:0] DP_CLEAR  = 4'd2;
    localparam logic [DP_W-1:0] DP_START  = 4'd3;
    localparam logic [DP_W-1:0] DP_MISS   = 4'd4;
    localparam logic [DP_W-1:0] DP_RD_HI  = 4'd5;
    localparam logic [DP_W-1:0] DP_LD_PIV = 4'd6;
    localparam logic [DP_W-1:0] DP_RD_I   = 4'd7;
    localparam logic [DP_W-1:0] DP_CMP    = 4'd8;
    localparam logic [DP_W-1:0] DP_SWP1   = 4'd9;
    localparam logic [DP_W-1:0] DP_SWP2   = 4'd10;
    localparam logic [DP_W-1:0] DP_RD_P   = 4'd11;
    localparam logic [DP_W-1:0] DP_FIN1   = 4'd12;
    localparam logic [DP_W-1:0] DP_FIN2   = 4'd13;
    localparam logic [DP_W-1:0] DP_EMIT   = 4'd14;

    typedef struct packed {
        logic [OP_W-1:0]              op;
        logic signed [DATA_WIDTH-1:0] elem_value;
        logic [K_W-1:0]               k_rank;
    } in_word_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] kth_value;
        logic                         found;
    } out_word_t;

    typedef struct packed {
        logic [DP_W-1:0] code;
    } cmd_t;

    typedef struct packed {
        logic k_ok;
        logic i_lt_hi;
        logic le;
        logic hit;
        logic out_busy;
    } status_t;

endpackage
`default_nettype wire

// ===== hdl/kss_datapath.sv =====
`default_nettype none
module kss_datapath (
    input  wire               clk,
    input  wire               rst_n,
    input  kss_pkg::in_word_t in_word,
    input  kss_pkg::cmd_t     cmd,
    output kss_pkg::status_t  status,
    output logic              out_valid,
    input  wire               out_stall,
    output kss_pkg::out_word_t out_word
);
    import kss_pkg::*;

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;
    logic [IDX_W-1:0]      raddr;
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [DATA_WIDTH-1:0] wdata;

    logic [CNT_W-1:0]      count_reg, count_next;
    logic [IDX_W-1:0]      lo_reg, lo_next;
    logic [IDX_W-1:0]      hi_reg, hi_next;
    logic [IDX_W-1:0]      i_reg, i_next;
    logic [IDX_W-1:0]      p_reg, p_next;
    logic [K_W-1:0]        kk_reg, kk_next;
    logic [DATA_WIDTH-1:0] pivot_reg, pivot_next;
    logic [DATA_WIDTH-1:0] tmp_reg, tmp_next;
    logic [DATA_WIDTH-1:0] res_value_reg, res_value_next;
    logic                  res_found_reg, res_found_next;
    logic                  out_valid_reg, out_valid_next;
    out_word_t             out_word_reg, out_word_next;

    logic [IDX_W-1:0]      rel;
    logic [K_W-1:0]        kk_m1;

    assign rel   = p_reg - lo_reg;
    assign kk_m1 = kk_reg - K_W'(1);

    assign status.k_ok     = (in_word.k_rank != '0) && (CNT_W'(in_word.k_rank) <= count_reg);
    assign status.i_lt_hi  = i_reg < hi_reg;
    assign status.le       = $signed(rdata_reg) <= $signed(pivot_reg);
    assign status.hit      = K_W'(rel) == kk_m1;
    assign status.out_busy = out_valid_reg && out_stall;

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_comb
    begin
        raddr          = i_reg;
        we             = 1'b0;
        waddr          = i_reg;
        wdata          = rdata_reg;
        count_next     = count_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        i_next         = i_reg;
        p_next         = p_reg;
        kk_next        = kk_reg;
        pivot_next     = pivot_reg;
        tmp_next       = tmp_reg;
        res_value_next = res_value_reg;
        res_found_next = res_found_reg;
        out_word_next  = out_word_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (cmd.code)
            DP_LOAD:
            begin
                if (count_reg < CNT_W'(DEPTH))
                begin
                    we         = 1'b1;
                    waddr      = count_reg[IDX_W-1:0];
                    wdata      = in_word.elem_value;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            DP_CLEAR:
            begin
                count_next = '0;
            end
            DP_START:
            begin
                lo_next = '0;
                hi_next = IDX_W'(count_reg - CNT_W'(1));
                kk_next = in_word.k_rank;
            end
            DP_MISS:
            begin
                res_value_next = INT_MAX;
                res_found_next = 1'b0;
            end
            DP_RD_HI:
            begin
                raddr  = hi_reg;
                i_next = lo_reg;
                p_next = lo_reg;
            end
            DP_LD_PIV:
            begin
                pivot_next = rdata_reg;
            end
            DP_RD_I:
            begin
                raddr = i_reg;
            end
            DP_CMP:
            begin
                if (status.le)
                begin
                    tmp_next = rdata_reg;
                    raddr    = p_reg;
                end
                else
                begin
                    i_next = i_reg + IDX_W'(1);
                end
            end
            DP_SWP1:
            begin
                we    = 1'b1;
                waddr = i_reg;
                wdata = rdata_reg;
            end
            DP_SWP2:
            begin
                we     = 1'b1;
                waddr  = p_reg;
                wdata  = tmp_reg;
                p_next = p_reg + IDX_W'(1);
                i_next = i_reg + IDX_W'(1);
            end
            DP_RD_P:
            begin
                raddr = p_reg;
            end
            DP_FIN1:
            begin
                we    = 1'b1;
                waddr = hi_reg;
                wdata = rdata_reg;
            end
            DP_FIN2:
            begin
                we    = 1'b1;
                waddr = p_reg;
                wdata = pivot_reg;
                if (status.hit)
                begin
                    res_value_next = pivot_reg;
                    res_found_next = 1'b1;
                end
                else if (K_W'(rel) > kk_m1)
                begin
                    hi_next = p_reg - IDX_W'(1);
                end
                else
                begin
                    kk_next = kk_m1 - K_W'(rel);
                    lo_next = p_reg + IDX_W'(1);
                end
            end
            DP_EMIT:
            begin
                out_valid_next          = 1'b1;
                out_word_next.kth_value = res_value_reg;
                out_word_next.found     = res_found_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        i_reg         <= i_next;
        p_reg         <= p_next;
        kk_reg        <= kk_next;
        pivot_reg     <= pivot_next;
        tmp_reg       <= tmp_next;
        res_value_reg <= res_value_next;
        res_found_reg <= res_found_next;
        out_word_reg  <= out_word_next;
    end

endmodule
`default_nettype wire

// ===== hdl/kss_ctrl.sv =====
`default_nettype none
module kss_ctrl (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    output logic                    in_stall,
    input  wire [kss_pkg::OP_W-1:0] op,
    input  kss_pkg::status_t        status,
    output kss_pkg::cmd_t           cmd
);
    import kss_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PIV_RD = 4'd1;
    localparam logic [3:0] S_PIV_LD = 4'd2;
    localparam logic [3:0] S_SCAN   = 4'd3;
    localparam logic [3:0] S_CMP    = 4'd4;
    localparam logic [3:0] S_SWP1   = 4'd5;
    localparam logic [3:0] S_SWP2   = 4'd6;
    localparam logic [3:0] S_FIN1   = 4'd7;
    localparam logic [3:0] S_FIN2   = 4'd8;
    localparam logic [3:0] S_EMIT   = 4'd9;

    logic [3:0] state_reg, state_next;

    assign in_stall = state_reg != S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        cmd.code   = DP_NOP;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (op)
                        OP_LOAD:  cmd.code = DP_LOAD;
                        OP_CLEAR: cmd.code = DP_CLEAR;
                        OP_SELECT:
                        begin
                            if (status.k_ok)
                            begin
                                cmd.code   = DP_START;
                                state_next = S_PIV_RD;
                            end
                            else
                            begin
                                cmd.code   = DP_MISS;
                                state_next = S_EMIT;
                            end
                        end
                        default:  cmd.code = DP_NOP;
                    endcase
                end
            end
            S_PIV_RD:
            begin
                cmd.code   = DP_RD_HI;
                state_next = S_PIV_LD;
            end
            S_PIV_LD:
            begin
                cmd.code   = DP_LD_PIV;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (status.i_lt_hi)
                begin
                    cmd.code   = DP_RD_I;
                    state_next = S_CMP;
                end
                else
                begin
                    cmd.code   = DP_RD_P;
                    state_next = S_FIN1;
                end
            end
            S_CMP:
            begin
                cmd.code   = DP_CMP;
                state_next = status.le ? S_SWP1 : S_SCAN;
            end
            S_SWP1:
            begin
                cmd.code   = DP_SWP1;
                state_next = S_SWP2;
            end
            S_SWP2:
            begin
                cmd.code   = DP_SWP2;
                state_next = S_SCAN;
            end
            S_FIN1:
            begin
                cmd.code   = DP_FIN1;
                state_next = S_FIN2;
            end
            S_FIN2:
            begin
                cmd.code   = DP_FIN2;
                state_next = status.hit ? S_EMIT : S_PIV_RD;
            end
            S_EMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.code   = DP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/kth_smallest_select.sv =====
// Load, clear and unused op words are taken while idle; a select holds the input off until done.
// Select: a start step, then passes over a shrinking range (read the pivot, compare each entry,
// swap through two writes on the one write port, place the pivot), then an emit step.
// Invalid rank: the miss result is set as the word is taken; the emit step then waits on stall.
// Reset clears the element count and output valid; the store is not cleared.
`default_nettype none
module kth_smallest_select (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_stall,
    input  kss_pkg::in_word_t   in_word,
    output logic                out_valid,
    input  wire                 out_stall,
    output kss_pkg::out_word_t  out_word
);
    import kss_pkg::*;

    cmd_t    cmd;
    status_t status;

    kss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .op       (in_word.op),
        .status   (status),
        .cmd      (cmd)
    );

    kss_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_word),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

endmodule
`default_nettype wire

// ===== bench/kth_smallest_select_test.sv =====
`timescale 1ns / 1ps

module kth_smallest_select_test;
    import kss_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic signed [DATA_WIDTH-1:0] MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam int RANDOM_ITEMS = 245;
    localparam int QUIET_TAIL   = 40;

    typedef struct {
        in_word_t  w;
        bit        typed;
        out_word_t want;
    } stim_row_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    in_word_t  in_word   = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    out_word_t out_word;

    int        held_vals[$];
    out_word_t pending_answers[$];
    int        mismatches = 0;
    int        items_sent = 0;
    int        long_hold  = 0;
    bit        tx_idle_on = 1'b1;
    bit        rx_idle_on = 1'b1;

    kth_smallest_select u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #200_000_000;
        $display("kth_smallest_select regression: fail");
        $finish;
    end

    function automatic in_word_t mk_word(input logic [OP_W-1:0] op,
                                         input logic signed [DATA_WIDTH-1:0] val,
                                         input logic [K_W-1:0] k);
        in_word_t w;
        w.op         = op;
        w.elem_value = val;
        w.k_rank     = k;
        return w;
    endfunction

    function automatic stim_row_t row(input logic [OP_W-1:0] op,
                                      input logic signed [DATA_WIDTH-1:0] val,
                                      input logic [K_W-1:0] k,
                                      input bit typed,
                                      input logic signed [DATA_WIDTH-1:0] kv,
                                      input bit f);
        stim_row_t r;
        r.w              = mk_word(op, val, k);
        r.typed          = typed;
        r.want.kth_value = kv;
        r.want.found     = f;
        return r;
    endfunction

    function automatic out_word_t rank_answer(input logic [K_W-1:0] k);
        out_word_t r;
        int        lt;
        int        le;
        r.kth_value = INT_MAX;
        r.found     = 1'b0;
        if (k >= 1 && k <= held_vals.size())
        begin
            r.found = 1'b1;
            for (int i = 0; i < held_vals.size(); i++)
            begin
                lt = 0;
                le = 0;
                for (int j = 0; j < held_vals.size(); j++)
                begin
                    if (held_vals[j] < held_vals[i])
                        lt++;
                    if (held_vals[j] <= held_vals[i])
                        le++;
                end
                if (lt < k && k <= le)
                    r.kth_value = held_vals[i];
            end
        end
        return r;
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] rand_val();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return int'($urandom_range(0, 8)) - 4;
            2: return MOST_NEG;
            3: return INT_MAX;
            4: return int'($urandom_range(0, 2000)) - 1000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
        if (tx_idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        case (w.op)
            OP_LOAD:
            begin
                if (held_vals.size() < DEPTH)
                    held_vals.push_back(w.elem_value);
            end
            OP_CLEAR:
                held_vals.delete();
            OP_SELECT:
                pending_answers.push_back(typed ? want : rank_answer(w.k_rank));
            default:
                ;
        endcase
        if (w.op != OP_UNUSED)
            items_sent++;
        @(negedge clk);
    endtask

    task automatic send_plain(input logic [OP_W-1:0] op,
                              input logic signed [DATA_WIDTH-1:0] val,
                              input logic [K_W-1:0] k);
        send_word(mk_word(op, val, k), 1'b0, '0);
    endtask

    // receiver: random stall bursts, plus the long hold-off when requested
    initial
    begin
        int burst;
        burst = 0;
        forever
        begin
            @(negedge clk);
            if (long_hold > 0)
            begin
                out_stall <= 1'b1;
                long_hold--;
            end
            else if (burst > 0)
            begin
                out_stall <= 1'b1;
                burst--;
            end
            else if (rx_idle_on && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                burst = $urandom_range(0, 5);
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: kth_value %0d found %0b",
                             out_word.kth_value, out_word.found);
            end
            else
            begin
                want = pending_answers.pop_front();
                if (out_word.kth_value !== want.kth_value)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("kth_value mismatch: expected %0d, got %0d",
                                 want.kth_value, out_word.kth_value);
                end
                if (out_word.found !== want.found)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("found mismatch: expected %0b, got %0b",
                                 want.found, out_word.found);
                end
            end
        end
    end

    initial
    begin
        stim_row_t        directed[$];
        int               start;
        int               n;
        int               pat;
        int               cnt;
        logic signed [DATA_WIDTH-1:0] base;
        logic [K_W-1:0]   k;

        directed.push_back(row(OP_SELECT, 0, 0, 1, INT_MAX, 0));
        directed.push_back(row(OP_SELECT, 0, 1, 1, INT_MAX, 0));
        directed.push_back(row(OP_UNUSED, -1, 2047, 1, INT_MAX, 0));
        directed.push_back(row(OP_SELECT, 0, 1, 1, INT_MAX, 0));
        directed.push_back(row(OP_LOAD, MOST_NEG, 0, 0, 0, 0));
        directed.push_back(row(OP_LOAD, INT_MAX, 2047, 0, 0, 0));
        directed.push_back(row(OP_LOAD, 0, 0, 0, 0, 0));
        directed.push_back(row(OP_LOAD, -1, 0, 0, 0, 0));
        directed.push_back(row(OP_LOAD, 5, 0, 0, 0, 0));
        directed.push_back(row(OP_SELECT, -1, 1, 1, MOST_NEG, 1));
        directed.push_back(row(OP_SELECT, 0, 5, 1, INT_MAX, 1));
        directed.push_back(row(OP_SELECT, 0, 3, 0, 0, 0));
        directed.push_back(row(OP_SELECT, 0, 6, 1, INT_MAX, 0));
        directed.push_back(row(OP_SELECT, 0, 2047, 1, INT_MAX, 0));
        directed.push_back(row(OP_SELECT, 0, 0, 1, INT_MAX, 0));
        directed.push_back(row(OP_CLEAR, -1, 2047, 0, 0, 0));
        directed.push_back(row(OP_SELECT, 0, 1, 1, INT_MAX, 0));
        directed.push_back(row(OP_LOAD, 7, 0, 0, 0, 0));
        directed.push_back(row(OP_LOAD, 7, 0, 0, 0, 0));
        directed.push_back(row(OP_LOAD, 7, 0, 0, 0, 0));
        directed.push_back(row(OP_SELECT, 0, 2, 0, 0, 0));
        directed.push_back(row(OP_LOAD, -7, 2047, 0, 0, 0));
        directed.push_back(row(OP_SELECT, 0, 1, 0, 0, 0));
        directed.push_back(row(OP_SELECT, 0, 4, 0, 0, 0));
        directed.push_back(row(OP_SELECT, 0, 5, 1, INT_MAX, 0));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[i])
            send_word(directed[i].w, directed[i].typed, directed[i].want);

        // hold the receiver off so selects back up into the input
        for (int i = 0; i < 8; i++)
            send_plain(OP_LOAD, rand_val(), 0);
        long_hold = 600;
        for (int i = 0; i < 8; i++)
            send_plain(OP_SELECT, 0, K_W'($urandom_range(0, 9)));

        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            if (items_sent - start >= RANDOM_ITEMS - QUIET_TAIL)
            begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            else
            begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end

            if ($urandom_range(0, 9) == 0)
            begin
                send_plain(OP_W'(OP_LOAD + $urandom_range(0, 3)), $urandom, K_W'($urandom));
            end
            else
            begin
                if ($urandom_range(0, 5) != 0)
                    send_plain(OP_CLEAR, $urandom, K_W'($urandom));
                n    = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48)
                                                   : $urandom_range(1, 12);
                pat  = $urandom_range(0, 3);
                base = rand_val();
                for (int i = 0; i < n; i++)
                begin
                    case (pat)
                        0: send_plain(OP_LOAD, rand_val(), K_W'($urandom));
                        1: send_plain(OP_LOAD, i * 3 - 20, K_W'($urandom));
                        2: send_plain(OP_LOAD, 100 - i, K_W'($urandom));
                        default: send_plain(OP_LOAD, base, K_W'($urandom));
                    endcase
                end
                repeat ($urandom_range(1, 4))
                begin
                    cnt = held_vals.size();
                    case ($urandom_range(0, 7))
                        0: k = '0;
                        1: k = K_W'(cnt + 1);
                        2: k = K_W'($urandom);
                        default: k = (cnt == 0) ? '0 : K_W'($urandom_range(1, cnt));
                    endcase
                    send_plain(OP_SELECT, $urandom, k);
                end
            end
        end

        in_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("kth_smallest_select regression: pass");
        else
            $display("kth_smallest_select regression: fail");
        $finish;
    end

endmodule
